// ===== hw/rtl/sev_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sev_pkg: shared types and constants of the stereo envelope gate
// Formats, register codes, queue entry, and the exp table builder.
// ----------------------------------------------------------------------------
package sev_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int EXP_TABLE_BITS = 10;

  localparam int TBL_N      = 1 << EXP_TABLE_BITS;
  localparam int ROM_DEPTH  = TBL_N + 1;
  localparam int IDX_BITS   = $clog2(ROM_DEPTH);
  localparam int ROM_BITS   = 31;
  localparam int GAIN_BITS  = 24;
  localparam int RATE_BITS  = 32;
  localparam int ENV_BITS   = 34;
  localparam int AVG_BITS   = 33;
  localparam int AVG_SHIFT  = 32 - SAMPLE_BITS;
  localparam int ENV_IDX_SHIFT = 33 - EXP_TABLE_BITS;
  localparam int MUL_BITS   = 64;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = 24'h80_0000;
  localparam logic [ENV_BITS-1:0]  ENV_MAX  = 34'h2_0000_0000;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_ATTACK    = 2'd1,
    REG_DECAY     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0] threshold_gain;
    logic [RATE_BITS-1:0] attack_rate;
    logic [RATE_BITS-1:0] decay_rate;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] mag_l;
    logic [SAMPLE_BITS-1:0] mag_r;
    logic                   neg_l;
    logic                   neg_r;
    logic [AVG_BITS-1:0]    avg;
  } entry_t;

  typedef logic [ROM_BITS-1:0] rom_t [0:ROM_DEPTH-1];

  // shift-and-subtract quotient
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(2k/N) in Q3.28 from a Taylor series in Q.40, rounded half up
  function automatic rom_t build_exp_rom();
    rom_t        rom;
    logic [63:0] term;
    logic [63:0] sum;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      term = 64'd1 << 40;
      sum  = term;
      for (int n = 1; n < 40; n++) begin
        if (term != 64'd0) begin
          term = udiv64(term * 64'(2 * k), 64'(TBL_N) * 64'(n));
          sum  = sum + term;
        end
      end
      rom[k] = ROM_BITS'((sum + 64'd2048) >> 12);
    end
    return rom;
  endfunction

endpackage

// ===== hw/rtl/sev_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sev_in_if: sample pair channel
// Valid/ready channel carrying one stereo sample pair per word.
// ----------------------------------------------------------------------------
interface sev_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sev_pkg::SAMPLE_BITS-1:0] left_sample;
  logic signed [sev_pkg::SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
  modport mon    (input valid, input left_sample, input right_sample, input ready);
endinterface

// ===== hw/rtl/sev_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sev_out_if: gated result channel
// Valid/ready channel carrying both gated samples and the gain per word.
// ----------------------------------------------------------------------------
interface sev_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sev_pkg::SAMPLE_BITS-1:0] left_result;
  logic signed [sev_pkg::SAMPLE_BITS-1:0] right_result;
  logic        [sev_pkg::GAIN_BITS-1:0]   applied_gain;

  modport source (output valid, output left_result, output right_result,
                  output applied_gain, input ready);
  modport sink   (input valid, input left_result, input right_result,
                  input applied_gain, output ready);
  modport mon    (input valid, input left_result, input right_result,
                  input applied_gain, input ready);
endinterface

// ===== hw/rtl/sev_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sev_front: input side of the gate
// Accepts sample pairs, forms magnitudes, signs and the average magnitude.
// ----------------------------------------------------------------------------
module sev_front (
  sev_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            push,
  output sev_pkg::entry_t push_entry
);

  localparam int SB = sev_pkg::SAMPLE_BITS;
  localparam int AW = sev_pkg::AVG_BITS;

  logic [SB-1:0] raw_l;
  logic [SB-1:0] raw_r;
  logic [SB:0]   mag_sum;

  assign raw_l = in_ch.left_sample;
  assign raw_r = in_ch.right_sample;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_entry.neg_l = raw_l[SB-1];
    push_entry.neg_r = raw_r[SB-1];
    // most negative code maps to full scale
    push_entry.mag_l = raw_l[SB-1] ? (~raw_l + 1'b1) : raw_l;
    push_entry.mag_r = raw_r[SB-1] ? (~raw_r + 1'b1) : raw_r;
    mag_sum          = {1'b0, push_entry.mag_l} + {1'b0, push_entry.mag_r};
    push_entry.avg   = AW'(mag_sum) << sev_pkg::AVG_SHIFT;
  end

endmodule

// ===== hw/rtl/sev_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sev_queue: short queue between front and back
// Small register queue of classified words.
// ----------------------------------------------------------------------------
module sev_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sev_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output sev_pkg::entry_t head
);

  localparam int PW = sev_pkg::QPTR_BITS;
  localparam int CW = sev_pkg::QCNT_BITS;

  sev_pkg::entry_t slot_r [0:sev_pkg::QDEPTH-1];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = (count_r == CW'(sev_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(sev_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(sev_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== hw/rtl/sev_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sev_back: envelope, gain and sample scaling
// Sequencer around one shared multiplier, exp table and output register.
// ----------------------------------------------------------------------------
module sev_back (
  input  logic            clk,
  input  logic            rst_n,
  input  sev_pkg::cfg_t   cfg,
  input  logic            q_empty,
  input  sev_pkg::entry_t q_head,
  output logic            pop,
  sev_out_if.source       out_ch
);

  localparam int SB  = sev_pkg::SAMPLE_BITS;
  localparam int EW  = sev_pkg::ENV_BITS;
  localparam int RW  = sev_pkg::RATE_BITS;
  localparam int GW  = sev_pkg::GAIN_BITS;
  localparam int OW  = sev_pkg::ROM_BITS;
  localparam int IW  = sev_pkg::IDX_BITS;
  localparam int MW  = sev_pkg::MUL_BITS;
  localparam int SW  = EW + 2;
  localparam int PGW = GW + OW;
  localparam int APW = SB + GW;

  localparam sev_pkg::rom_t EXP_ROM = sev_pkg::build_exp_rom();

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_STEP = 9'b000000010,
    S_ENV  = 9'b000000100,
    S_ROM  = 9'b000001000,
    S_GMUL = 9'b000010000,
    S_GAIN = 9'b000100000,
    S_LMUL = 9'b001000000,
    S_RMUL = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [EW-1:0]   env_r, env_nxt;
  sev_pkg::entry_t ent_r;
  logic [EW-1:0]   d_r;
  logic            up_r;
  logic [MW-1:0]   prod_r;
  logic [OW-1:0]   rom_r;
  logic [GW-1:0]   gain_r, gain_nxt;
  logic [SB-1:0]   lres_r;
  logic            out_valid_r, out_valid_nxt;
  logic [SB-1:0]   out_left_r;
  logic [SB-1:0]   out_right_r;
  logic [GW-1:0]   out_gain_r;

  logic            out_load;
  logic            start;
  logic [EW-1:0]   avg_ext;
  logic            up_now;
  logic [EW-1:0]   d_now;
  logic [RW-1:0]   rate_sel;
  logic [31:0]     mul_a;
  logic [31:0]     mul_b;
  logic            mul_en;
  logic [MW-1:0]   mul_p;
  logic [SW-1:0]   step;
  logic [SW-1:0]   env_wide;
  logic [EW-1:0]   idx_full;
  logic [IW-1:0]   rom_idx;
  logic [PGW:0]    gsum;
  logic [PGW-28:0] gfull;

  function automatic logic [SB-1:0] apply_round(input logic [APW-1:0] p, input logic neg);
    logic [APW:0]  s;
    logic [SB-1:0] r;
    s = {1'b0, p} + (APW+1)'(1 << 22);
    r = s[SB+22:23];
    return neg ? (~r + 1'b1) : r;
  endfunction

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign start    = (state_r == S_IDLE) || out_load;
  assign pop      = start && !q_empty;

  // difference against the envelope
  assign avg_ext = {1'b0, q_head.avg};
  assign up_now  = avg_ext > env_r;
  assign d_now   = up_now ? (avg_ext - env_r) : (env_r - avg_ext);

  assign rate_sel = up_r ? cfg.attack_rate : cfg.decay_rate;

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (state_r)
      S_STEP: begin
        mul_a = rate_sel;
        mul_b = d_r[31:0];
      end
      S_GMUL: begin
        mul_a = 32'(cfg.threshold_gain);
        mul_b = 32'(rom_r);
      end
      S_LMUL: begin
        mul_a = 32'(ent_r.mag_l);
        mul_b = 32'(gain_r);
      end
      S_RMUL: begin
        mul_a = 32'(ent_r.mag_r);
        mul_b = 32'(gain_r);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign mul_p = MW'(mul_a) * MW'(mul_b);

  // envelope move: high bits of the difference are at most two
  always_comb begin
    step = SW'(prod_r[MW-1:32])
         + (d_r[33] ? SW'({rate_sel, 1'b0}) : '0)
         + (d_r[32] ? SW'(rate_sel) : '0);
    if (up_r) begin
      env_wide = SW'(env_r) + step;
    end else begin
      env_wide = (step > SW'(env_r)) ? '0 : (SW'(env_r) - step);
    end
    env_nxt = (env_wide > SW'(sev_pkg::ENV_MAX)) ? sev_pkg::ENV_MAX : env_wide[EW-1:0];
  end

  assign idx_full = env_r >> sev_pkg::ENV_IDX_SHIFT;
  assign rom_idx  = (idx_full > EW'(sev_pkg::TBL_N)) ? IW'(sev_pkg::TBL_N)
                                                    : idx_full[IW-1:0];

  always_comb begin
    gsum     = {1'b0, prod_r[PGW-1:0]} + (PGW+1)'(1 << 27);
    gfull    = gsum[PGW:28];
    gain_nxt = (gfull > (PGW-27)'(sev_pkg::GAIN_ONE)) ? sev_pkg::GAIN_ONE : gfull[GW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (pop) state_nxt = S_STEP;
      S_STEP: state_nxt = S_ENV;
      S_ENV:  state_nxt = S_ROM;
      S_ROM:  state_nxt = S_GMUL;
      S_GMUL: state_nxt = S_GAIN;
      S_GAIN: state_nxt = S_LMUL;
      S_LMUL: state_nxt = S_RMUL;
      S_RMUL: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = pop ? S_STEP : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      env_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_ENV) begin
        env_r <= env_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= q_head;
      d_r   <= d_now;
      up_r  <= up_now;
    end
    if (mul_en) begin
      prod_r <= mul_p;
    end
    if (state_r == S_ROM) begin
      rom_r <= EXP_ROM[rom_idx];
    end
    if (state_r == S_GAIN) begin
      gain_r <= gain_nxt;
    end
    if (state_r == S_RMUL) begin
      lres_r <= apply_round(prod_r[APW-1:0], ent_r.neg_l);
    end
    if (out_load) begin
      out_left_r  <= lres_r;
      out_right_r <= apply_round(prod_r[APW-1:0], ent_r.neg_r);
      out_gain_r  <= gain_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.left_result  = out_left_r;
  assign out_ch.right_result = out_right_r;
  assign out_ch.applied_gain = out_gain_r;

endmodule

// ===== hw/rtl/stereo_envelope_gate_gain_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_envelope_gate_gain_top: stereo envelope noise gate
// Envelope follower with exp-table gain applied to both channels.
//
//   channel   direction  handshake           word
//   in_ch     sink       valid/ready         left_sample, right_sample
//   out_ch    source     valid/ready         left_result, right_result, applied_gain
//   cfg_*     sink       write enable only   cfg_index, cfg_data
//
// the back end runs each pair through step product, envelope update, exp
// table read, gain product, gain rounding, left and right products and
// load, all products on the one shared multiplier; a new pair is taken
// only as the last result loads; the front keeps filling a 2-deep queue meanwhile
// synchronous active-low reset clears envelope, queue and valid flags
// ----------------------------------------------------------------------------
module stereo_envelope_gate_gain_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  sev_in_if.sink                               in_ch,
  sev_out_if.source                            out_ch,
  input  logic                                 cfg_we,
  input  logic [sev_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [sev_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  sev_pkg::cfg_t   cfg_r, cfg_nxt;
  logic            push;
  sev_pkg::entry_t push_entry;
  logic            q_full;
  logic            q_empty;
  logic            pop;
  sev_pkg::entry_t q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (sev_pkg::reg_idx_t'(cfg_index))
        sev_pkg::REG_THRESHOLD: cfg_nxt.threshold_gain = cfg_data[sev_pkg::GAIN_BITS-1:0];
        sev_pkg::REG_ATTACK:    cfg_nxt.attack_rate    = cfg_data[sev_pkg::RATE_BITS-1:0];
        sev_pkg::REG_DECAY:     cfg_nxt.decay_rate     = cfg_data[sev_pkg::RATE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_gain <= sev_pkg::GAIN_ONE;
      cfg_r.attack_rate    <= '0;
      cfg_r.decay_rate     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sev_front u_front (
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  sev_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  sev_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== hw/rtl/sev_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sev_checker: port-level checks of the stereo gate
// Watches both channels over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module sev_checker (
  input logic        clk,
  input logic        rst_n,
  sev_in_if.sink     in_ch,
  sev_out_if.source  out_ch
);

  // reset leaves an empty queue and no pending result
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_ch.valid && in_ch.ready))
    else $error("state after reset not clean");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.left_result)
      && $stable(out_ch.right_result) && $stable(out_ch.applied_gain)))
    else $error("result word dropped or changed while stalled");

  a_gain_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.applied_gain <= sev_pkg::GAIN_ONE))
    else $error("gain above unity");

  // zero gain mutes both channels
  a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.applied_gain == '0))
      |-> ((out_ch.left_result == '0) && (out_ch.right_result == '0)))
    else $error("nonzero result with zero gain");

endmodule

bind stereo_envelope_gate_gain_top sev_checker u_sev_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

// ===== verif/tb_stereo_envelope_gate_gain_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_envelope_gate_gain_top: self-checking bench for the stereo gate
// Sends sample pairs and register writes while both channels stall at random.
// Each accepted pair is run through a local fixed-point copy of the envelope
// follower and exp-table gain. Every result word is checked, field by field
// and in order, against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_stereo_envelope_gate_gain_top;

  localparam int SB           = sev_pkg::SAMPLE_BITS;
  localparam int GW           = sev_pkg::GAIN_BITS;
  localparam int RW           = sev_pkg::RATE_BITS;
  localparam int TBL_LEN      = (1 << sev_pkg::EXP_TABLE_BITS) + 1;
  localparam int CHUNK_PAIRS  = 40;
  localparam int CHUNKS       = 6;
  localparam int DRAIN_CYCLES = 24;
  localparam logic [sev_pkg::CFG_IDX_BITS-1:0] REG_UNMAPPED = 2'd3;

  typedef logic signed [SB-1:0] sample_t;

  typedef struct packed {
    sample_t       left;
    sample_t       right;
    logic [GW-1:0] gain;
  } gated_word_t;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              cfg_we;
  logic [sev_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [sev_pkg::CFG_DATA_BITS-1:0] cfg_data;

  sev_in_if  in_bus ();
  sev_out_if out_bus ();

  stereo_envelope_gate_gain_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // gate state mirrored from the register writes and accepted pairs
  logic [GW-1:0]                thr_q23;
  logic [RW-1:0]                rise_coef;
  logic [RW-1:0]                fall_coef;
  logic [sev_pkg::ENV_BITS-1:0] env_q32;
  logic [30:0]                  exp_q28 [0:TBL_LEN-1];

  gated_word_t pending_gated_q[$];
  int          send_idle_pct;
  int          sink_stall_pct;
  int          errors;

  // exp(2k/N) in Q3.28, series summed in Q.40 then rounded half up
  task automatic fill_exp_table();
    logic [63:0] term;
    logic [63:0] acc;
    for (int k = 0; k < TBL_LEN; k++) begin
      term = 64'd1 << 40;
      acc  = term;
      for (int n = 1; n < 40 && term != 64'd0; n++) begin
        term = (term * 64'(2 * k)) / (64'(TBL_LEN - 1) * 64'(n));
        acc  = acc + term;
      end
      exp_q28[k] = 31'((acc + 64'd2048) >> 12);
    end
  endtask

  function automatic logic [SB:0] sample_mag(sample_t s);
    logic [SB:0] ext;
    ext = {s[SB-1], s};
    return s[SB-1] ? -ext : ext;
  endfunction

  function automatic logic [63:0] envelope_step(logic [RW-1:0] coef,
                                                logic [63:0] diff);
    logic [95:0] prod;
    prod = 96'(coef) * 96'(diff);
    return prod[95:32];
  endfunction

  function automatic sample_t scale_sample(sample_t s, logic [GW-1:0] g);
    logic [63:0]   r;
    logic [SB-1:0] rl;
    r  = (64'(sample_mag(s)) * 64'(g) + (64'd1 << 22)) >> 23;
    rl = r[SB-1:0];
    return s[SB-1] ? -rl : rl;
  endfunction

  function automatic gated_word_t gate_pair(sample_t l, sample_t r);
    logic [63:0] level;
    logic [63:0] avg;
    logic [63:0] step;
    logic [63:0] idx;
    logic [63:0] gprod;
    gated_word_t w;
    level = 64'(env_q32);
    avg   = (64'(sample_mag(l)) + 64'(sample_mag(r))) << (32 - SB);
    if (avg > level) begin
      level = level + envelope_step(rise_coef, avg - level);
    end else begin
      step  = envelope_step(fall_coef, level - avg);
      level = (step > level) ? 64'd0 : level - step;
    end
    if (level > 64'(sev_pkg::ENV_MAX)) level = 64'(sev_pkg::ENV_MAX);
    env_q32 = level[sev_pkg::ENV_BITS-1:0];
    idx = level >> (33 - sev_pkg::EXP_TABLE_BITS);
    if (idx > 64'(TBL_LEN - 1)) idx = 64'(TBL_LEN - 1);
    gprod = (64'(thr_q23) * 64'(exp_q28[idx[sev_pkg::IDX_BITS-1:0]]) + (64'd1 << 27)) >> 28;
    if (gprod > 64'(sev_pkg::GAIN_ONE)) gprod = 64'(sev_pkg::GAIN_ONE);
    w.gain  = gprod[GW-1:0];
    w.left  = scale_sample(l, w.gain);
    w.right = scale_sample(r, w.gain);
    return w;
  endfunction

  function automatic void note_mismatch(string field, logic [31:0] want,
                                        logic [31:0] got);
    errors++;
    $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endfunction

  // register mirror, prediction, result check and sink stalls
  always @(posedge clk) begin
    gated_word_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          sev_pkg::REG_THRESHOLD: thr_q23   = cfg_data[GW-1:0];
          sev_pkg::REG_ATTACK:    rise_coef = cfg_data[RW-1:0];
          sev_pkg::REG_DECAY:     fall_coef = cfg_data[RW-1:0];
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready)
        pending_gated_q.push_back(gate_pair(in_bus.left_sample, in_bus.right_sample));
      if (out_bus.valid && out_bus.ready) begin
        if (pending_gated_q.size() == 0) begin
          note_mismatch("unexpected word, left", 32'hx, 32'(out_bus.left_result));
        end else begin
          want = pending_gated_q.pop_front();
          if (out_bus.left_result !== want.left)
            note_mismatch("left_result", 32'(want.left), 32'(out_bus.left_result));
          if (out_bus.right_result !== want.right)
            note_mismatch("right_result", 32'(want.right), 32'(out_bus.right_result));
          if (out_bus.applied_gain !== want.gain)
            note_mismatch("applied_gain", 32'(want.gain), 32'(out_bus.applied_gain));
        end
      end
      out_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end else begin
      out_bus.ready <= 1'b0;
    end
  end

  // valid stays high from one word to the next unless the source idles
  task automatic send_pair(sample_t l, sample_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.left_sample  <= l;
    in_bus.right_sample <= r;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_gated_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [sev_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [sev_pkg::CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_gate(logic [31:0] thr, logic [31:0] atk, logic [31:0] dcy);
    write_reg(sev_pkg::REG_THRESHOLD, thr);
    write_reg(sev_pkg::REG_ATTACK, atk);
    write_reg(sev_pkg::REG_DECAY, dcy);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic sample_t pick_sample(int shift);
    if ($urandom_range(0, 15) == 0)
      return $urandom_range(0, 1) ? sample_t'(24'h7F_FFFF) : sample_t'(24'h80_0000);
    return sample_t'($signed($urandom) >>> shift);
  endfunction

  function automatic logic [31:0] pick_threshold();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'(sev_pkg::GAIN_ONE);
      2:       return $urandom;
      default: return $urandom_range(0, sev_pkg::GAIN_ONE);
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // defaults: unity threshold, frozen envelope, so words pass unchanged
  task automatic test_passthrough_after_reset();
    send_pair(24'h00_0000, 24'h00_0000);
    send_pair(24'h7F_FFFF, 24'h80_0000);
    send_pair(24'h80_0000, 24'h80_0000);
    send_pair(24'h7F_FFFF, 24'h7F_FFFF);
    send_pair(24'h00_0001, 24'hFF_FFFF);
    send_pair(24'h55_5555, 24'hAA_AAAA);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    program_gate(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // unmapped index must leave all registers alone
    write_reg(REG_UNMAPPED, 32'd0);
    cfg_we <= 1'b0;
    @(posedge clk);
    repeat (4) send_pair(24'h80_0000, 24'h80_0000);
    repeat (2) send_pair(24'h00_0000, 24'h00_0000);
    wait_drained();
    program_gate(32'd0, 32'h8000_0000, 32'd1);
    send_pair(24'h7F_FFFF, 24'h80_0000);
    send_pair(24'h12_3456, 24'hED_CBAA);
    wait_drained();
    program_gate(32'd1, 32'h4000_0000, 32'h8000_0000);
    repeat (3) send_pair(24'h7F_FFFF, 24'h7F_FFFF);
    wait_drained();
    program_gate(32'h0030_0000, 32'h0100_0000, 32'h0010_0000);
    send_pair(24'h80_0000, 24'h00_0000);
    send_pair(24'h00_0000, 24'h7F_FFFF);
    send_pair(24'h40_0000, 24'hC0_0000);
    wait_drained();
  endtask

  // loud and quiet bursts so the envelope sweeps up and down the table
  task automatic test_random_traffic(int idle_pct, int stall_pct);
    int seg_left;
    int shift;
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    seg_left = 0;
    shift    = 0;
    for (int c = 0; c < CHUNKS; c++) begin
      wait_drained();
      program_gate(pick_threshold(), pick_rate(), pick_rate());
      for (int i = 0; i < CHUNK_PAIRS; i++) begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 12);
          if ($urandom_range(0, 3) == 0) shift = $urandom_range(0, SB - 1);
          else shift = $urandom_range(0, 1) ? 0 : 20;
        end
        send_pair(pick_sample(shift), pick_sample(shift));
        seg_left--;
      end
    end
  endtask

  initial begin
    errors         = 0;
    send_idle_pct  = 6;
    sink_stall_pct = 80;
    thr_q23        = sev_pkg::GAIN_ONE;
    rise_coef      = '0;
    fall_coef      = '0;
    env_q32        = '0;
    fill_exp_table();
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    in_bus.valid        <= 1'b0;
    in_bus.left_sample  <= '0;
    in_bus.right_sample <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_passthrough_after_reset();
    test_register_extremes();
    test_random_traffic(6, 80);
    test_random_traffic(80, 6);
    test_random_traffic(0, 0);
    wait_drained();

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== stereo_envelope_gate_gain_top.f =====
hw/rtl/sev_pkg.sv
hw/rtl/sev_in_if.sv
hw/rtl/sev_out_if.sv
hw/rtl/sev_front.sv
hw/rtl/sev_queue.sv
hw/rtl/sev_back.sv
hw/rtl/stereo_envelope_gate_gain_top.sv
hw/rtl/sev_checker.sv
verif/tb_stereo_envelope_gate_gain_top.sv
